[rtl/bmp_stream_to_rgba_decoder_core_macros.svh]
// ----------------------------------------------------------------------------
// bmp_stream_to_rgba_decoder_core_macros
// Assertion macros of the decoder RTL
// ----------------------------------------------------------------------------
`ifndef BMP_STREAM_TO_RGBA_DECODER_CORE_MACROS_SVH
`define BMP_STREAM_TO_RGBA_DECODER_CORE_MACROS_SVH

// checked on every clock edge outside reset
`define BMPDEC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define BMPDEC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/bmpdec_pkg.sv]
// ----------------------------------------------------------------------------
// bmpdec_pkg
// Types and constants of the streaming BMP to RGBA decoder
// ----------------------------------------------------------------------------
package bmpdec_pkg;

    // header layout
    localparam int unsigned HEADER_BYTES = 54;
    localparam logic [5:0]  POS_MARK0    = 6'd0;
    localparam logic [5:0]  POS_MARK1    = 6'd1;
    localparam logic [5:0]  POS_OFF_LO   = 6'd10;
    localparam logic [5:0]  POS_OFF_HI   = 6'd11;
    localparam logic [5:0]  POS_WID_LO   = 6'd18;
    localparam logic [5:0]  POS_WID_HI   = 6'd19;
    localparam logic [5:0]  POS_HGT_LO   = 6'd22;
    localparam logic [5:0]  POS_HGT_HI   = 6'd23;
    localparam logic [5:0]  POS_DEPTH    = 6'd28;
    localparam logic [5:0]  POS_HDR_END  = 6'd53;

    localparam logic [7:0]  CHAR_B       = 8'h42;
    localparam logic [7:0]  CHAR_M       = 8'h4D;
    localparam logic [7:0]  BPP_24       = 8'd24;
    localparam logic [7:0]  BPP_32       = 8'd32;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

    localparam logic [2:0]  CH_NONE      = 3'd0;
    localparam logic [2:0]  CH_RGB       = 3'd3;
    localparam logic [2:0]  CH_RGBA      = 3'd4;

    localparam logic        KIND_PIXEL   = 1'b0;
    localparam logic        KIND_STATUS  = 1'b1;

    // output queue
    localparam int unsigned FIFO_DEPTH   = 8;
    localparam int unsigned FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W        = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned CREDIT_LIMIT = FIFO_DEPTH - 2;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT_HDR  = 3'd1,
        ST_NO_BM      = 3'd2,
        ST_BAD_DEPTH  = 3'd3,
        ST_TRUNCATED  = 3'd4,
        ST_LOW_OFFSET = 3'd5
    } t_status;

    // one decoded byte, handed from the parser to the result stage
    typedef struct packed {
        logic        pix_valid;
        logic        stat_valid;
        logic [15:0] row_y;
        logic [15:0] column;
        logic [15:0] pix_width;
        logic [15:0] pix_height;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        t_status     status;
        logic [15:0] stat_width;
        logic [15:0] stat_height;
    } t_job;

    // one result transaction
    typedef struct packed {
        logic        kind;
        logic [31:0] pixel_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        t_status     status;
        logic [15:0] width;
        logic [15:0] height;
        logic        last;
    } t_result;

endpackage

[rtl/bmp_stream_to_rgba_decoder_core.sv]
// ----------------------------------------------------------------------------
// bmp_stream_to_rgba_decoder_core
// Streaming BMP (24/32 bpp) decoder emitting RGBA pixels and a final status
// ----------------------------------------------------------------------------
// channel   dir  tdata                       tuser       tlast
// s         in   data_byte                   -           end_of_file
// m         out  index,r,g,b,a,status,w,h    item_kind   last_result
//
// One file byte is taken per cycle while input ready is high. A byte passes
// the parser register, then the index multiply writes its result into the
// result queue. The last byte of a file yields up to two transactions; the queue
// of eight entries absorbs them and input ready drops only when the queue plus
// the result in flight could not take two more. Synchronous active-low reset
// empties the queue and starts a new file; the last byte also starts one.
// ----------------------------------------------------------------------------
`include "bmp_stream_to_rgba_decoder_core_macros.svh"

module bmp_stream_to_rgba_decoder_core
    import bmpdec_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] data_byte
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata,   // [31:0] pixel_index, [39:32] red, [47:40] green,
                                      // [55:48] blue, [63:56] alpha, [66:64] decode_status,
                                      // [82:67] image_width, [98:83] image_height, zero above
    output logic         o_m_tuser,   // [0] item_kind
    output logic         o_m_tlast
);

    logic             s_accept;
    t_job             w_job;
    logic [1:0]       w_push_cnt;
    t_result          w_first;
    t_result          w_second;
    t_result          w_head;
    logic [CNT_W-1:0] w_count;
    logic [CNT_W-1:0] w_pending;

    // input credit against the queue
    assign w_pending  = w_count + CNT_W'(w_push_cnt);
    assign o_s_tready = (w_pending <= CNT_W'(CREDIT_LIMIT));
    assign s_accept   = i_s_tvalid && o_s_tready;

    bmpdec_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_data   (i_s_tdata),
        .i_eof    (i_s_tlast),
        .o_job    (w_job)
    );

    bmpdec_result u_result (
        .i_job      (w_job),
        .o_push_cnt (w_push_cnt),
        .o_first    (w_first),
        .o_second   (w_second)
    );

    bmpdec_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_first    (w_first),
        .i_second   (w_second),
        .i_pop      (i_m_tready),
        .o_valid    (o_m_tvalid),
        .o_head     (w_head),
        .o_count    (w_count)
    );

    // output packing
    assign o_m_tdata = {5'b0, w_head.height, w_head.width, w_head.status, w_head.alpha,
                        w_head.blue, w_head.green, w_head.red, w_head.pixel_index};
    assign o_m_tuser = w_head.kind;
    assign o_m_tlast = w_head.last;

    // checks
    `BMPDEC_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_m_tvalid, "queue not empty after reset")
    `BMPDEC_ASSERT(a_fifo_bound, w_count <= CNT_W'(FIFO_DEPTH), "result queue overflow")
    `BMPDEC_ASSERT(a_eof_status, s_accept && i_s_tlast |=> w_job.stat_valid, "no status for last byte")
    `BMPDEC_ASSERT(a_last_is_status, o_m_tvalid && o_m_tlast |-> o_m_tuser == KIND_STATUS, "last result is not a status")

endmodule

[rtl/bmpdec_parser.sv]
// ----------------------------------------------------------------------------
// bmpdec_parser
// Header capture, pixel byte gathering and end-of-file status per input byte
// ----------------------------------------------------------------------------
module bmpdec_parser
    import bmpdec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data,
    input  logic        i_eof,
    output t_job        o_job
);

    logic [31:0] r_pos,     n_pos;
    logic [15:0] r_off,     n_off;
    logic [15:0] r_width,   n_width;
    logic [15:0] r_height,  n_height;
    logic [2:0]  r_ch,      n_ch;
    logic [15:0] r_row,     n_row;
    logic [15:0] r_col,     n_col;
    logic [17:0] r_sbc,     n_sbc;
    logic [1:0]  r_k,       n_k;
    logic [31:0] r_gather,  n_gather;
    t_status     r_err,     n_err;
    t_job        r_job,     n_job;

    logic        in_header;
    logic        in_data;
    logic        is_rgba;
    logic [17:0] line_bytes;
    logic [17:0] line_p3;
    logic [17:0] padded;
    logic [17:0] sbc_inc;
    logic [1:0]  last_k;
    logic        emit;
    logic [32:0] total;
    t_status     stat;

    assign in_header  = (r_pos < 32'(HEADER_BYTES));
    assign is_rgba    = (r_ch == CH_RGBA);
    assign line_bytes = is_rgba ? {r_width, 2'b00}
                                : ({2'b00, r_width} + {1'b0, r_width, 1'b0});
    assign line_p3    = line_bytes + 18'd3;
    assign padded     = {line_p3[17:2], 2'b00};
    assign sbc_inc    = r_sbc + 18'd1;
    assign last_k     = is_rgba ? 2'd3 : 2'd2;
    assign total      = {1'b0, r_pos} + 33'd1;
    assign in_data    = !in_header && (r_pos >= {16'b0, r_off}) && (r_err == ST_OK)
                        && (r_width != 16'd0) && (r_height != 16'd0)
                        && (r_row < r_height) && ((r_ch == CH_RGB) || is_rgba);

    // next state for one accepted byte
    always_comb begin
        n_pos    = (r_pos != '1) ? r_pos + 32'd1 : r_pos;
        n_off    = r_off;
        n_width  = r_width;
        n_height = r_height;
        n_ch     = r_ch;
        n_row    = r_row;
        n_col    = r_col;
        n_sbc    = r_sbc;
        n_k      = r_k;
        n_gather = r_gather;
        n_err    = r_err;
        emit     = 1'b0;

        if (in_header) begin
            case (r_pos[5:0])
                POS_MARK0: begin
                    if (i_data != CHAR_B && r_err == ST_OK) n_err = ST_NO_BM;
                end
                POS_MARK1: begin
                    if (i_data != CHAR_M && r_err == ST_OK) n_err = ST_NO_BM;
                end
                POS_OFF_LO: n_off    = {8'h00, i_data};
                POS_OFF_HI: n_off    = {i_data, r_off[7:0]};
                POS_WID_LO: n_width  = {8'h00, i_data};
                POS_WID_HI: n_width  = {i_data, r_width[7:0]};
                POS_HGT_LO: n_height = {8'h00, i_data};
                POS_HGT_HI: n_height = {i_data, r_height[7:0]};
                POS_DEPTH: begin
                    if (i_data == BPP_24) begin
                        n_ch = CH_RGB;
                    end else if (i_data == BPP_32) begin
                        n_ch = CH_RGBA;
                    end else begin
                        n_ch = CH_NONE;
                        if (r_err == ST_OK) n_err = ST_BAD_DEPTH;
                    end
                end
                POS_HDR_END: begin
                    if (r_err == ST_OK && r_off < 16'(HEADER_BYTES)) n_err = ST_LOW_OFFSET;
                end
                default: ;
            endcase
        end else if (in_data) begin
            // gather pixel bytes, padding bytes are skipped
            if (r_sbc < line_bytes) begin
                if (r_k == 2'd0) begin
                    n_gather = {24'b0, i_data};
                end else begin
                    n_gather = r_gather | ({24'b0, i_data} << {r_k, 3'b000});
                end
                if (r_k == last_k) begin
                    emit  = 1'b1;
                    n_col = r_col + 16'd1;
                    n_k   = 2'd0;
                end else begin
                    n_k   = r_k + 2'd1;
                end
            end
            // scanline wrap
            if (sbc_inc >= padded) begin
                n_sbc = '0;
                n_col = '0;
                n_k   = 2'd0;
                n_row = r_row + 16'd1;
            end else begin
                n_sbc = sbc_inc;
            end
        end
    end

    // end-of-file status, priority short header first
    always_comb begin
        if (r_pos < 32'(HEADER_BYTES - 1)) begin
            stat = ST_SHORT_HDR;
        end else if (n_err != ST_OK) begin
            stat = n_err;
        end else if ((total < {17'b0, n_off})
                     || (n_width != 16'd0 && n_height != 16'd0 && n_row < n_height)) begin
            stat = ST_TRUNCATED;
        end else begin
            stat = ST_OK;
        end
    end

    // job for the result stage
    always_comb begin
        n_job             = r_job;
        n_job.pix_valid   = i_accept && emit;
        n_job.stat_valid  = i_accept && i_eof;
        if (i_accept) begin
            n_job.row_y       = r_height - 16'd1 - r_row;
            n_job.column      = r_col;
            n_job.pix_width   = r_width;
            n_job.pix_height  = r_height;
            n_job.red         = is_rgba ? n_gather[31:24] : n_gather[23:16];
            n_job.green       = is_rgba ? n_gather[23:16] : n_gather[15:8];
            n_job.blue        = is_rgba ? n_gather[15:8]  : n_gather[7:0];
            n_job.alpha       = is_rgba ? n_gather[7:0]   : ALPHA_OPAQUE;
            n_job.status      = stat;
            n_job.stat_width  = n_width;
            n_job.stat_height = n_height;
        end
    end

    // decoder state, cleared after the last byte of a file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_eof)) begin
            r_pos    <= '0;
            r_off    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_ch     <= CH_NONE;
            r_row    <= '0;
            r_col    <= '0;
            r_sbc    <= '0;
            r_k      <= '0;
            r_gather <= '0;
            r_err    <= ST_OK;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_off    <= n_off;
            r_width  <= n_width;
            r_height <= n_height;
            r_ch     <= n_ch;
            r_row    <= n_row;
            r_col    <= n_col;
            r_sbc    <= n_sbc;
            r_k      <= n_k;
            r_gather <= n_gather;
            r_err    <= n_err;
        end
    end

    // job register, cleared in reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job <= '0;
        end else begin
            r_job <= n_job;
        end
    end

    assign o_job = r_job;

endmodule

[rtl/bmpdec_result.sv]
// ----------------------------------------------------------------------------
// bmpdec_result
// Destination index calculation and result formatting
// ----------------------------------------------------------------------------
module bmpdec_result
    import bmpdec_pkg::*;
(
    input  t_job        i_job,
    output logic [1:0]  o_push_cnt,
    output t_result     o_first,
    output t_result     o_second
);

    logic [31:0] row_base;
    logic [31:0] pix_index;
    t_result     pix_res;
    t_result     stat_res;

    // top-down index: y * width + x
    assign row_base  = 32'(i_job.row_y) * 32'(i_job.pix_width);
    assign pix_index = row_base + {16'b0, i_job.column};

    // pixel transaction
    always_comb begin
        pix_res.kind        = KIND_PIXEL;
        pix_res.pixel_index = pix_index;
        pix_res.red         = i_job.red;
        pix_res.green       = i_job.green;
        pix_res.blue        = i_job.blue;
        pix_res.alpha       = i_job.alpha;
        pix_res.status      = ST_OK;
        pix_res.width       = i_job.pix_width;
        pix_res.height      = i_job.pix_height;
        pix_res.last        = 1'b0;
    end

    // status transaction
    always_comb begin
        stat_res.kind        = KIND_STATUS;
        stat_res.pixel_index = '0;
        stat_res.red         = '0;
        stat_res.green       = '0;
        stat_res.blue        = '0;
        stat_res.alpha       = '0;
        stat_res.status      = i_job.status;
        stat_res.width       = i_job.stat_width;
        stat_res.height      = i_job.stat_height;
        stat_res.last        = 1'b1;
    end

    // pixel goes ahead of the status
    assign o_push_cnt = {1'b0, i_job.pix_valid} + {1'b0, i_job.stat_valid};
    assign o_first    = i_job.pix_valid ? pix_res : stat_res;
    assign o_second   = stat_res;

endmodule

[rtl/bmpdec_fifo.sv]
// ----------------------------------------------------------------------------
// bmpdec_fifo
// Result queue taking up to two transactions per cycle, one out per cycle while popped
// ----------------------------------------------------------------------------
module bmpdec_fifo
    import bmpdec_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_cnt,
    input  t_result          i_first,
    input  t_result          i_second,
    input  logic             i_pop,
    output logic             o_valid,
    output t_result          o_head,
    output logic [CNT_W-1:0] o_count
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp, n_wp;
    logic [FIFO_AW-1:0]   r_rp, n_rp;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 pop;
    logic [FIFO_AW-1:0]   wp_next;

    assign pop     = i_pop && (r_count != '0);
    assign wp_next = r_wp + FIFO_AW'(1);

    // pointer and fill level update
    always_comb begin
        n_wp    = r_wp + FIFO_AW'(i_push_cnt);
        n_rp    = pop ? r_rp + FIFO_AW'(1) : r_rp;
        n_count = r_count + CNT_W'(i_push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) r_mem[r_wp]    <= i_first;
        if (i_push_cnt == 2'd2) r_mem[wp_next] <= i_second;
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rp];
    assign o_count = r_count;

endmodule
